>>> hdl/clbe_pkg.sv
// Package with the constants, the root table and the isqrt helper of the series core.
`default_nettype none
package clbe_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_COEF = 6;
    localparam int COEF_W = 32;
    localparam int IDX_W = 3;
    localparam logic [29:0] LOG2_TEN_Q28 = 30'd891723283;
    localparam logic [30:0] MANT_ONE = 31'h4000_0000;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res = '0;
        rem = v;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-i) in Q30, truncated, for i = 1..16 (index 0 is i = 1).
    function automatic logic [30:0] root_q30(input logic [3:0] i);
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        for (int k = 0; k < 15; k++) begin
            if (k < int'(i)) r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/chebyshev_log_background_eval_core.sv
// Top level of the pipelined order-five Chebyshev series and power-of-ten core.
// Usage: write coef0..coef5 through cfg_wr_en, cfg_index and cfg_data while idle
// (indices above five are ignored). Samples enter on s_valid/s_ready with
// s_x_value; each transfer yields exactly one result on m_valid/m_ready
// carrying m_series_value, m_pow_exponent, m_pow_mantissa and m_range_flag.
// The core is a 28-stage pipeline: the four Chebyshev recurrence products,
// five coefficient products plus a shifted constant term with a registered
// adder tree, the log2(10) product in two partial products, and sixteen
// mantissa products, one per stage. A result is valid once it has passed all
// stages; one sample is taken every cycle unless the output stalls. When the
// receiver stalls the whole pipeline holds, so s_ready follows m_ready or an
// empty output slot. Reset clears the valid bits and sets all coefficients to zero.
`default_nettype none
module chebyshev_log_background_eval_core #(
    parameter int FRAC_BITS = clbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [clbe_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [clbe_pkg::COEF_W-1:0]  cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [17:0]           s_x_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [31:0]                m_series_value,
    output logic signed [7:0]                 m_pow_exponent,
    output logic [15:0]                       m_pow_mantissa,
    output logic                              m_range_flag
);
    import clbe_pkg::*;

    localparam int NST = 28;
    localparam int TW = FRAC_BITS + 2;
    localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;
    localparam logic signed [TW+FRAC_BITS+1:0] HALF = (TW+FRAC_BITS+2)'(1) <<< (FRAC_BITS-1);

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [NST-1:0] vld_reg;
    logic adv;

    assign adv = m_ready || !vld_reg[NST-1];
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) coef_reg[i] <= '0;
            vld_reg <= '0;
        end else begin
            if (cfg_wr_en && cfg_index < IDX_W'(NUM_COEF)) coef_reg[cfg_index] <= cfg_data;
            if (adv) vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    function automatic logic signed [TW-1:0] rmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b + (2*TW)'(HALF);
        return TW'(p >>> FRAC_BITS);
    endfunction

    // Stage 1: clamp; stages 2..5: recurrence.
    logic signed [TW-1:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [TW-1:0] t2_reg, t2b_reg, t3_reg, t2c_reg, t3b_reg, t4_reg;
    logic signed [TW-1:0] t5_reg, t4b_reg, t3c_reg, t2d_reg, x5_reg;
    logic signed [TW-1:0] x_cl;
    always_comb begin
        if (s_x_value > 18'sd0 && 32'(s_x_value) > 32'(ONE)) x_cl = ONE;
        else if (32'(s_x_value) < -32'(ONE)) x_cl = -ONE;
        else x_cl = TW'(s_x_value);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg <= x_cl;
            x2_reg <= x1_reg;
            t2_reg <= TW'(2 * rmul(x1_reg, x1_reg) - ONE);
            x3_reg <= x2_reg;
            t2b_reg <= t2_reg;
            t3_reg <= TW'(2 * rmul(x2_reg, t2_reg) - x2_reg);
            x4_reg <= x3_reg;
            t2c_reg <= t2b_reg;
            t3b_reg <= t3_reg;
            t4_reg <= TW'(2 * rmul(x3_reg, t3_reg) - t2b_reg);
            x5_reg <= x4_reg;
            t2d_reg <= t2c_reg;
            t3c_reg <= t3b_reg;
            t4b_reg <= t4_reg;
            t5_reg <= TW'(2 * rmul(x4_reg, t4_reg) - t3b_reg);
        end
    end

    // Stage 6: coefficient products; 7: pair sums; 8: total; 9: round and saturate.
    localparam int PW = COEF_W + TW;
    logic signed [PW-1:0] p_reg [NUM_COEF];
    logic signed [PW+1:0] q_reg [3];
    logic signed [PW+2:0] acc_reg;
    logic signed [31:0] s_reg;
    logic sflag_reg;
    logic signed [PW+2:0] accr;
    always_comb accr = (acc_reg + (PW+3)'(HALF)) >>> FRAC_BITS;
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= PW'(coef_reg[0]) <<< FRAC_BITS;
            p_reg[1] <= coef_reg[1] * x5_reg;
            p_reg[2] <= coef_reg[2] * t2d_reg;
            p_reg[3] <= coef_reg[3] * t3c_reg;
            p_reg[4] <= coef_reg[4] * t4b_reg;
            p_reg[5] <= coef_reg[5] * t5_reg;
            for (int i = 0; i < 3; i++)
                q_reg[i] <= (PW+2)'(p_reg[2*i]) + (PW+2)'(p_reg[2*i+1]);
            acc_reg <= (PW+3)'(q_reg[0]) + (PW+3)'(q_reg[1]) + (PW+3)'(q_reg[2]);
            if (accr > (PW+3)'(32'sh7fffffff)) begin
                s_reg <= 32'sh7fffffff; sflag_reg <= 1'b1;
            end else if (accr < -(PW+3)'(64'sh80000000)) begin
                s_reg <= 32'sh80000000; sflag_reg <= 1'b1;
            end else begin
                s_reg <= 32'(accr); sflag_reg <= 1'b0;
            end
        end
    end

    // Stages 10..11: w = s * log2(10) in two partial products.
    logic signed [46:0] wlo_reg;
    logic signed [46:0] whi;
    logic signed [31:0] s10_reg, s11_reg;
    logic f10_reg, f11_reg;
    logic signed [62:0] w_reg;
    always_comb whi = s10_reg * $signed({1'b0, LOG2_TEN_Q28[29:15]});
    always_ff @(posedge aclk) begin
        if (adv) begin
            wlo_reg <= s_reg * $signed({1'b0, LOG2_TEN_Q28[14:0]});
            s10_reg <= s_reg;
            f10_reg <= sflag_reg;
            w_reg <= (63'(whi) <<< 15) + 63'(wlo_reg);
            s11_reg <= s10_reg;
            f11_reg <= f10_reg;
        end
    end

    // Stage 12: exponent and fraction bits.
    logic signed [62:0] e_full;
    logic [15:0] fb;
    assign e_full = w_reg >>> (FRAC_BITS + 28);
    assign fb = 16'(w_reg >>> (FRAC_BITS + 12));

    localparam int MS = 16;
    logic [30:0] m_reg [MS+1];
    logic [15:0] fb_reg [MS+1];
    logic signed [7:0] e_reg [MS+1];
    logic sat_reg [MS+1];
    logic [15:0] smant_reg [MS+1];
    logic fl_reg [MS+1];
    logic signed [31:0] sv_reg [MS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg[0] <= MANT_ONE;
            fb_reg[0] <= fb;
            sv_reg[0] <= s11_reg;
            if (e_full > 63'sd127) begin
                e_reg[0] <= 8'sd127; sat_reg[0] <= 1'b1; smant_reg[0] <= 16'hffff;
                fl_reg[0] <= 1'b1;
            end else if (e_full < -63'sd128) begin
                e_reg[0] <= -8'sd128; sat_reg[0] <= 1'b1; smant_reg[0] <= 16'h8000;
                fl_reg[0] <= 1'b1;
            end else begin
                e_reg[0] <= 8'(e_full); sat_reg[0] <= 1'b0; smant_reg[0] <= 16'h8000;
                fl_reg[0] <= f11_reg;
            end
        end
    end

    // Stages 13..28: one mantissa product per stage, a register after each product.
    for (genvar g = 0; g < MS; g++) begin : g_mant
        localparam logic [30:0] ROOT = root_q30(4'(g));
        logic [61:0] pa;
        logic [30:0] ma;
        always_comb begin
            pa = 62'(m_reg[g]) * 62'(ROOT);
            ma = fb_reg[g][15-g] ? 31'(pa >> 30) : m_reg[g];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                m_reg[g+1] <= ma;
                fb_reg[g+1] <= fb_reg[g];
                e_reg[g+1] <= e_reg[g];
                sat_reg[g+1] <= sat_reg[g];
                smant_reg[g+1] <= smant_reg[g];
                fl_reg[g+1] <= fl_reg[g];
                sv_reg[g+1] <= sv_reg[g];
            end
        end
    end

    assign m_series_value = sv_reg[MS];
    assign m_pow_exponent = e_reg[MS];
    assign m_pow_mantissa = sat_reg[MS] ? smant_reg[MS] : 16'(m_reg[MS] >> 15);
    assign m_range_flag = fl_reg[MS];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_series_value))
        else $error("result changed during stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("ready low with empty output");
    a_mant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pow_mantissa[15]) else $error("mantissa not normalised");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0]) else $error("transfer lost");
`endif
endmodule
`default_nettype wire
